[rtl/assert_macros.svh]
// Assertion macros for the retransmit table RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock, off while in reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[rtl/art_pkg.sv]
// Types, constants and codes for the retransmit table.
// Used by art_ctrl, art_dp and ack_retransmit_table.
package art_pkg;

  localparam int Depth    = 16;
  localparam int IdxW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW     = $clog2(Depth + 1);
  localparam int SeqW     = 32;
  localparam int TimeW    = 32;
  localparam int AttW     = 8;
  localparam int RetryW   = 16;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 1;
  localparam int OpW      = 2;
  localparam int KindW    = 2;
  localparam int InDataW  = SeqW + TimeW;
  localparam int OutDataW = SeqW + AttW;

  localparam logic [OpW-1:0] OpSend = 2'd0;
  localparam logic [OpW-1:0] OpAck  = 2'd1;
  localparam logic [OpW-1:0] OpTick = 2'd2;

  localparam logic [KindW-1:0] KindResend = 2'd0;
  localparam logic [KindW-1:0] KindGaveUp = 2'd1;
  localparam logic [KindW-1:0] KindFull   = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgRetryMs    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxRetries = 1'b1;

  localparam logic [RetryW-1:0] RetryMsReset    = 16'd100;
  localparam logic [AttW-1:0]   MaxRetriesReset = 8'd3;

  typedef struct packed {
    logic [SeqW-1:0]  seq;
    logic [AttW-1:0]  att;
    logic [TimeW-1:0] sent;
  } entry_t;

  typedef struct packed {
    logic do_send;
    logic start_fwd;
    logic start_bwd;
    logic rd;
    logic ack_eval;
    logic tick_eval;
    logic flush;
    logic comp_init;
    logic comp_eval;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic last_fwd;
    logic idx_zero;
    logic match;
    logic any_drop;
    logic stall;
    logic hold_valid;
    logic out_free;
  } sts_t;

endpackage

[rtl/art_ctrl.sv]
// Sequencer for the retransmit table: accepts transactions and steps the
// datapath through ack scans, tick walks and compaction. Uses art_pkg.
module art_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [art_pkg::OpW-1:0] in_op_i,
  output logic                  in_ready_o,
  input  art_pkg::sts_t         sts_i,
  output art_pkg::cmd_t         cmd_o
);
  import art_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SAckRd = 3'd1;
  localparam logic [2:0] SAckEv = 3'd2;
  localparam logic [2:0] STckRd = 3'd3;
  localparam logic [2:0] STckEv = 3'd4;
  localparam logic [2:0] SFlush = 3'd5;
  localparam logic [2:0] SCmpRd = 3'd6;
  localparam logic [2:0] SCmpEv = 3'd7;

  logic [2:0] state_q, state_d;
  logic       fire;

  assign in_ready_o = (state_q == SIdle) && sts_i.out_free;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (fire) begin
          unique case (in_op_i)
            OpSend: cmd_o.do_send = 1'b1;
            OpAck: begin
              cmd_o.start_fwd = 1'b1;
              if (!sts_i.count_zero) state_d = SAckRd;
            end
            OpTick: begin
              cmd_o.start_bwd = 1'b1;
              if (!sts_i.count_zero) state_d = STckRd;
            end
            default: ;
          endcase
        end
      end
      SAckRd: begin
        cmd_o.rd = 1'b1;
        state_d  = SAckEv;
      end
      SAckEv: begin
        cmd_o.ack_eval = 1'b1;
        if (sts_i.last_fwd) begin
          if (sts_i.match || sts_i.any_drop) begin
            cmd_o.comp_init = 1'b1;
            state_d         = SCmpRd;
          end else begin
            state_d = SIdle;
          end
        end else begin
          state_d = SAckRd;
        end
      end
      STckRd: begin
        cmd_o.rd = 1'b1;
        state_d  = STckEv;
      end
      STckEv: begin
        if (!sts_i.stall) begin
          cmd_o.tick_eval = 1'b1;
          state_d         = sts_i.idx_zero ? SFlush : STckRd;
        end
      end
      SFlush: begin
        if (sts_i.out_free || !sts_i.hold_valid) begin
          cmd_o.flush = 1'b1;
          if (sts_i.any_drop) begin
            cmd_o.comp_init = 1'b1;
            state_d         = SCmpRd;
          end else begin
            state_d = SIdle;
          end
        end
      end
      SCmpRd: begin
        cmd_o.rd = 1'b1;
        state_d  = SCmpEv;
      end
      SCmpEv: begin
        cmd_o.comp_eval = 1'b1;
        state_d         = sts_i.last_fwd ? SIdle : SCmpRd;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/art_dp.sv]
// Datapath of the retransmit table: entry memory, counters, keep mask,
// held result, output register and configuration. Uses art_pkg, assert_macros.svh.
`include "assert_macros.svh"

module art_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [art_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [art_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic [art_pkg::SeqW-1:0]         in_seq_i,
  input  logic [art_pkg::TimeW-1:0]        in_now_i,
  input  art_pkg::cmd_t                    cmd_i,
  output art_pkg::sts_t                    sts_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [art_pkg::KindW-1:0]        out_kind_o,
  output logic [art_pkg::SeqW-1:0]         out_seq_o,
  output logic [art_pkg::AttW-1:0]         out_att_o,
  output logic                             out_last_o
);
  import art_pkg::*;

  entry_t              mem [Depth];
  entry_t              rdata_q;
  logic                we;
  logic [IdxW-1:0]     waddr;
  entry_t              wdata;

  logic [RetryW-1:0]   retry_q;
  logic [AttW-1:0]     max_q;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     wr_q, wr_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [Depth-1:0]    keep_q, keep_d;
  logic                drop_q, drop_d;
  logic [SeqW-1:0]     req_seq_q;
  logic [TimeW-1:0]    req_now_q;

  logic                hold_valid_q, hold_valid_d;
  logic [KindW-1:0]    hold_kind_q, hold_kind_d;
  logic [SeqW-1:0]     hold_seq_q, hold_seq_d;
  logic [AttW-1:0]     hold_att_q, hold_att_d;

  logic                out_valid_q, out_valid_d;
  logic [KindW-1:0]    out_kind_q, out_kind_d;
  logic [SeqW-1:0]     out_seq_q, out_seq_d;
  logic [AttW-1:0]     out_att_q, out_att_d;
  logic                out_last_q, out_last_d;

  logic [TimeW-1:0]    elapsed;
  logic                due, give_up, match, out_free, last_fwd;
  logic [AttW-1:0]     att_inc;

  assign out_free = !out_valid_q || out_ready_i;
  assign elapsed  = req_now_q - rdata_q.sent;
  assign due      = elapsed >= TimeW'(retry_q);
  assign give_up  = rdata_q.att >= max_q;
  assign att_inc  = (rdata_q.att == {AttW{1'b1}}) ? rdata_q.att : rdata_q.att + AttW'(1);
  assign match    = rdata_q.seq == req_seq_q;
  assign last_fwd = (CntW'(idx_q) + CntW'(1)) == count_q;

  always_comb begin
    sts_o            = '0;
    sts_o.count_zero = count_q == '0;
    sts_o.last_fwd   = last_fwd;
    sts_o.idx_zero   = idx_q == '0;
    sts_o.match      = match;
    sts_o.any_drop   = drop_q;
    sts_o.stall      = due && hold_valid_q && !out_free;
    sts_o.hold_valid = hold_valid_q;
    sts_o.out_free   = out_free;
  end

  always_comb begin
    count_d      = count_q;
    wr_d         = wr_q;
    idx_d        = idx_q;
    keep_d       = keep_q;
    drop_d       = drop_q;
    hold_valid_d = hold_valid_q;
    hold_kind_d  = hold_kind_q;
    hold_seq_d   = hold_seq_q;
    hold_att_d   = hold_att_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_kind_d   = out_kind_q;
    out_seq_d    = out_seq_q;
    out_att_d    = out_att_q;
    out_last_d   = out_last_q;
    we           = 1'b0;
    waddr        = idx_q;
    wdata        = rdata_q;

    if (cmd_i.do_send) begin
      if (count_q == CntW'(Depth)) begin
        out_valid_d = 1'b1;
        out_kind_d  = KindFull;
        out_seq_d   = in_seq_i;
        out_att_d   = '0;
        out_last_d  = 1'b1;
      end else begin
        we         = 1'b1;
        waddr      = count_q[IdxW-1:0];
        wdata.seq  = in_seq_i;
        wdata.att  = AttW'(1);
        wdata.sent = in_now_i;
        count_d    = count_q + CntW'(1);
      end
    end

    if (cmd_i.start_fwd || cmd_i.start_bwd) begin
      keep_d = '1;
      drop_d = 1'b0;
      idx_d  = cmd_i.start_fwd ? '0 : IdxW'(count_q - CntW'(1));
    end

    if (cmd_i.ack_eval) begin
      if (match) begin
        keep_d[idx_q] = 1'b0;
        drop_d        = 1'b1;
      end
      idx_d = idx_q + IdxW'(1);
    end

    if (cmd_i.tick_eval) begin
      if (due) begin
        if (hold_valid_q) begin
          out_valid_d = 1'b1;
          out_kind_d  = hold_kind_q;
          out_seq_d   = hold_seq_q;
          out_att_d   = hold_att_q;
          out_last_d  = 1'b0;
        end
        hold_valid_d = 1'b1;
        hold_kind_d  = give_up ? KindGaveUp : KindResend;
        hold_seq_d   = rdata_q.seq;
        hold_att_d   = rdata_q.att;
        if (give_up) begin
          keep_d[idx_q] = 1'b0;
          drop_d        = 1'b1;
        end else begin
          we         = 1'b1;
          waddr      = idx_q;
          wdata.att  = att_inc;
          wdata.sent = req_now_q;
        end
      end
      idx_d = idx_q - IdxW'(1);
    end

    if (cmd_i.flush && hold_valid_q) begin
      out_valid_d  = 1'b1;
      out_kind_d   = hold_kind_q;
      out_seq_d    = hold_seq_q;
      out_att_d    = hold_att_q;
      out_last_d   = 1'b1;
      hold_valid_d = 1'b0;
    end

    if (cmd_i.comp_eval) begin
      if (keep_q[idx_q]) begin
        we    = 1'b1;
        waddr = wr_q[IdxW-1:0];
        wdata = rdata_q;
        wr_d  = wr_q + CntW'(1);
      end
      idx_d = idx_q + IdxW'(1);
      if (last_fwd) count_d = wr_d;
    end

    if (cmd_i.comp_init) begin
      idx_d = '0;
      wr_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_i.rd) rdata_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_q      <= RetryMsReset;
      max_q        <= MaxRetriesReset;
      count_q      <= '0;
      wr_q         <= '0;
      idx_q        <= '0;
      keep_q       <= '1;
      drop_q       <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgRetryMs:    retry_q <= cfg_data_i[RetryW-1:0];
          CfgMaxRetries: max_q   <= cfg_data_i[AttW-1:0];
          default: ;
        endcase
      end
      count_q      <= count_d;
      wr_q         <= wr_d;
      idx_q        <= idx_d;
      keep_q       <= keep_d;
      drop_q       <= drop_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_fwd || cmd_i.start_bwd) begin
      req_seq_q <= in_seq_i;
      req_now_q <= in_now_i;
    end
    hold_kind_q <= hold_kind_d;
    hold_seq_q  <= hold_seq_d;
    hold_att_q  <= hold_att_d;
    out_kind_q  <= out_kind_d;
    out_seq_q   <= out_seq_d;
    out_att_q   <= out_att_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_seq_o   = out_seq_q;
  assign out_att_o   = out_att_q;
  assign out_last_o  = out_last_q;

  `ASSERT_AT(count_in_range_a, clk_i, rst_ni, count_q <= CntW'(Depth))
  `ASSERT_IMPL(comp_wr_behind_rd_a, clk_i, rst_ni, cmd_i.comp_eval, wr_q <= CntW'(idx_q))
  `ASSERT_IMPL(no_eval_on_stall_a, clk_i, rst_ni, cmd_i.tick_eval, !sts_o.stall)

endmodule

[rtl/ack_retransmit_table.sv]
// Top level of the ack retransmit table: controller plus datapath.
// Depends on art_pkg, art_ctrl and art_dp.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser op, tdata {now_ms, seq}
//  m_axis    out  m_axis_tvalid/m_axis_tready   tuser kind, tdata {attempts, seq}, tlast
//  cfg       in   cfg_we_i                      cfg_idx_i, cfg_data_i
//
// Send stores an entry or reports full. Ack reads then evaluates each entry, oldest
// first, and compacts if any matched. Tick walks them newest first, flushes the held result
// and compacts if one gave up. The entry memory is single-port with registered read data.
// Reset clears the entry count; no clearing pass. A busy output stalls a tick walk.
module ack_retransmit_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [art_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [art_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [art_pkg::OpW-1:0]         s_axis_tuser,  // op
  input  logic [art_pkg::InDataW-1:0]     s_axis_tdata,  // seq, now_ms
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [art_pkg::KindW-1:0]       m_axis_tuser,  // kind
  output logic [art_pkg::OutDataW-1:0]    m_axis_tdata,  // seq_out, attempts_out
  output logic                            m_axis_tlast
);
  import art_pkg::*;

  cmd_t            cmd;
  sts_t            sts;
  logic [SeqW-1:0] out_seq;
  logic [AttW-1:0] out_att;

  art_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  art_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_seq_i    (s_axis_tdata[SeqW-1:0]),
    .in_now_i    (s_axis_tdata[SeqW+TimeW-1:SeqW]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (m_axis_tuser),
    .out_seq_o   (out_seq),
    .out_att_o   (out_att),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_att, out_seq};

endmodule

[tb/testbench.sv]
// Self-checking testbench for ack_retransmit_table: directed and random send/ack/tick
// traffic, checked against an in-bench model of the pending-message table.
// Depends on art_pkg and the ack_retransmit_table RTL.
`timescale 1ns / 1ps

module testbench;
  import art_pkg::*;

  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int SettleCycles = 4 * Depth + 8;
  localparam int DrainLimit   = 200000;
  localparam int LimitCycles  = 1000000;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [SeqW-1:0]  seq;
    logic [AttW-1:0]  att;
    logic             last;
  } notice_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [OpW-1:0]      s_axis_tuser;   // op
  logic [InDataW-1:0]  s_axis_tdata;   // seq, now_ms
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [KindW-1:0]    m_axis_tuser;   // kind
  logic [OutDataW-1:0] m_axis_tdata;   // seq_out, attempts_out
  logic                m_axis_tlast;

  // table model
  logic [SeqW-1:0]   tbl_seq  [Depth];
  logic [AttW-1:0]   tbl_att  [Depth];
  logic [TimeW-1:0]  tbl_sent [Depth];
  int                tbl_count;
  logic [RetryW-1:0] cur_retry_ms;
  logic [AttW-1:0]   cur_max_retries;

  notice_t           notice_q[$];
  logic [SeqW-1:0]   sent_pool[$];
  logic [TimeW-1:0]  wall_ms;
  bit                idle_en;
  int                error_count;

  ack_retransmit_table DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  function automatic void drop_entry(input int idx);
    for (int j = idx; j + 1 < tbl_count; j++) begin
      tbl_seq[j]  = tbl_seq[j + 1];
      tbl_att[j]  = tbl_att[j + 1];
      tbl_sent[j] = tbl_sent[j + 1];
    end
    tbl_count--;
  endfunction

  function automatic void step_table(input logic [OpW-1:0] op, input logic [SeqW-1:0] seq,
                                     input logic [TimeW-1:0] now);
    notice_t          res[$];
    notice_t          n;
    int               i;
    logic [TimeW-1:0] elapsed;
    case (op)
      OpSend: begin
        if (tbl_count >= Depth) begin
          n = '{kind: KindFull, seq: seq, att: '0, last: 1'b0};
          res.push_back(n);
        end else begin
          tbl_seq[tbl_count]  = seq;
          tbl_att[tbl_count]  = 8'd1;
          tbl_sent[tbl_count] = now;
          tbl_count++;
        end
      end
      OpAck: begin
        i = 0;
        while (i < tbl_count) begin
          if (tbl_seq[i] == seq) drop_entry(i);
          else i++;
        end
      end
      OpTick: begin
        // newest entry first
        i = tbl_count;
        while (i > 0) begin
          i--;
          elapsed = now - tbl_sent[i];
          if (elapsed < 32'(cur_retry_ms)) continue;
          if (tbl_att[i] >= cur_max_retries) begin
            n = '{kind: KindGaveUp, seq: tbl_seq[i], att: tbl_att[i], last: 1'b0};
            res.push_back(n);
            drop_entry(i);
          end else begin
            n = '{kind: KindResend, seq: tbl_seq[i], att: tbl_att[i], last: 1'b0};
            res.push_back(n);
            if (tbl_att[i] != 8'hFF) tbl_att[i]++;
            tbl_sent[i] = now;
          end
        end
      end
      default: ;
    endcase
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[k]) notice_q.push_back(res[k]);
  endfunction

  task automatic check_notice();
    notice_t want;
    if (notice_q.size() == 0) begin
      report_mismatch("result with none expected", 64'(m_axis_tdata), '0);
      return;
    end
    want = notice_q.pop_front();
    if (m_axis_tuser !== want.kind)
      report_mismatch("kind", 64'(m_axis_tuser), 64'(want.kind));
    if (m_axis_tdata[SeqW-1:0] !== want.seq)
      report_mismatch("seq_out", 64'(m_axis_tdata[SeqW-1:0]), 64'(want.seq));
    if (m_axis_tdata[OutDataW-1:SeqW] !== want.att)
      report_mismatch("attempts_out", 64'(m_axis_tdata[OutDataW-1:SeqW]), 64'(want.att));
    if (m_axis_tlast !== want.last)
      report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (s_axis_tvalid && s_axis_tready)
        step_table(s_axis_tuser, s_axis_tdata[SeqW-1:0], s_axis_tdata[InDataW-1:SeqW]);
      if (m_axis_tvalid && m_axis_tready) check_notice();
    end
  end

  function automatic int draw_gap();
    if (!idle_en || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  // result side
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_gap();
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_item(input logic [OpW-1:0] op, input logic [SeqW-1:0] seq,
                           input logic [TimeW-1:0] now);
    int gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {now, seq};
    if (op == OpSend) begin
      sent_pool.push_back(seq);
      if (sent_pool.size() > 24) void'(sent_pool.pop_front());
    end
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // hold off until every result is out and the block has settled
  task automatic drain();
    int waited;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (notice_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == CfgRetryMs) cur_retry_ms = data[RetryW-1:0];
    else cur_max_retries = data[AttW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // reset defaults, wrapping elapsed time, retry then give-up, ignored op
  task automatic test_basic_timing();
    idle_en = 1'b1;
    send_item(OpSend, 32'h0000_0000, 32'hFFFF_FFC0);
    send_item(OpSend, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    send_item(OpSend, 32'h0000_1234, 32'h0000_0000);
    send_item(OpUnused, 32'hA5A5_5A5A, 32'hFFFF_FFFF);
    send_item(OpTick, 32'h0, 32'd35);
    send_item(OpTick, 32'h0, 32'd36);
    send_item(OpAck, 32'h0000_1234, 32'h0);
    send_item(OpAck, 32'h5555_AAAA, 32'h0);
    send_item(OpTick, 32'h0, 32'd136);
    send_item(OpTick, 32'h0, 32'd236);
    send_item(OpTick, 32'hFFFF_FFFF, 32'd400);
    drain();
  endtask

  // fill past capacity, one ack for several duplicate entries, one tick with a result per entry
  task automatic test_table_full();
    int k;
    idle_en = 1'b0;
    write_reg(CfgMaxRetries, 16'd2);
    k = 0;
    while (tbl_count < Depth) begin
      send_item(OpSend, (k % 3 == 0) ? 32'h7 : $urandom, 32'h8000_0000);
      k++;
    end
    send_item(OpSend, 32'hDEAD_BEEF, 32'h8000_0000);
    send_item(OpSend, 32'h0000_0001, 32'h8000_0001);
    drain();
    idle_en = 1'b1;
    send_item(OpTick, 32'h0, 32'h8000_1000);
    drain();
    send_item(OpAck, 32'h7, 32'h0);
    send_item(OpTick, 32'h0, 32'h8000_2000);
    drain();
  endtask

  // register extremes; limits apply at the tick, not at the send
  task automatic test_register_extremes();
    write_reg(CfgRetryMs, 16'hFFFF);
    write_reg(CfgMaxRetries, 16'h00FF);
    send_item(OpSend, 32'hCAFE_0001, 32'd0);
    send_item(OpTick, 32'h0, 32'd65534);
    send_item(OpTick, 32'h0, 32'd65535);
    drain();
    write_reg(CfgMaxRetries, 16'd1);
    send_item(OpTick, 32'h0, 32'd131070);
    drain();
    write_reg(CfgRetryMs, 16'd1);
    write_reg(CfgMaxRetries, 16'd0);
    send_item(OpSend, 32'hCAFE_0002, 32'd5);
    send_item(OpTick, 32'h0, 32'd5);
    send_item(OpTick, 32'h0, 32'd6);
    drain();
  endtask

  task automatic random_item();
    int               pick;
    logic [SeqW-1:0]  seq;
    pick = $urandom_range(0, 99);
    wall_ms += $urandom_range(0, 3);
    if (pick < 40) begin
      if (sent_pool.size() > 0 && $urandom_range(0, 4) == 0)
        seq = sent_pool[$urandom_range(0, sent_pool.size() - 1)];
      else
        seq = $urandom;
      send_item(OpSend, seq, wall_ms);
    end else if (pick < 65) begin
      if (sent_pool.size() > 0 && $urandom_range(0, 9) < 7)
        seq = sent_pool[$urandom_range(0, sent_pool.size() - 1)];
      else
        seq = $urandom;
      send_item(OpAck, seq, $urandom);
    end else if (pick < 92) begin
      wall_ms += $urandom_range(0, 2 * int'(cur_retry_ms));
      send_item(OpTick, $urandom, wall_ms);
    end else if (pick < 96) begin
      send_item(OpTick, $urandom, $urandom);
    end else begin
      send_item(OpUnused, $urandom, $urandom);
    end
  endtask

  task automatic test_random_traffic();
    for (int round = 0; round < 5; round++) begin
      idle_en = (round % 2 == 0);
      case (round)
        0: begin
          write_reg(CfgRetryMs, 16'($urandom_range(1, 20)));
          write_reg(CfgMaxRetries, 16'($urandom_range(1, 4)));
        end
        1: begin
          write_reg(CfgRetryMs, 16'($urandom_range(50, 500)));
          write_reg(CfgMaxRetries, 16'($urandom_range(1, 8)));
        end
        2: begin
          write_reg(CfgRetryMs, 16'hFFFF);
          write_reg(CfgMaxRetries, 16'h00FF);
        end
        3: begin
          write_reg(CfgRetryMs, 16'($urandom_range(1, 65535)));
          write_reg(CfgMaxRetries, 16'($urandom_range(1, 255)));
        end
        default: begin
          write_reg(CfgRetryMs, 16'd1);
          write_reg(CfgMaxRetries, 16'($urandom_range(2, 3)));
        end
      endcase
      wall_ms = $urandom;
      for (int n = 0; n < 42; n++) random_item();
      drain();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tuser    = '0;
    s_axis_tdata    = '0;
    tbl_count       = 0;
    cur_retry_ms    = RetryMsReset;
    cur_max_retries = MaxRetriesReset;
    error_count     = 0;
    idle_en         = 1'b1;
    wall_ms         = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_timing();
    test_table_full();
    test_register_extremes();
    test_random_traffic();

    drain();
    if (notice_q.size() != 0)
      report_mismatch("results never delivered", '0, 64'(notice_q.size()));
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    repeat (LimitCycles) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/art_pkg.sv
rtl/art_ctrl.sv
rtl/art_dp.sv
rtl/ack_retransmit_table.sv
tb/testbench.sv
